/* rtl/bcdcet_pkg.sv */
// ----------------------------------------------------------------------------
// bcdcet_pkg
// Shared types, command codes and display tables of the countdown timer.
// ----------------------------------------------------------------------------
package bcdcet_pkg;

  localparam int unsigned NumDigitsDefault = 4;

  // Command codes carried on the slave-side tuser
  localparam logic [2:0] CmdTick   = 3'd0;
  localparam logic [2:0] CmdEncode = 3'd1;
  localparam logic [2:0] CmdCursor = 3'd2;
  localparam logic [2:0] CmdStart  = 3'd3;
  localparam logic [2:0] CmdScan   = 3'd4;

  // Configuration register indexes
  localparam logic RegTicksPerSecond = 1'b0;

  localparam logic [7:0] TicksPerSecondReset = 8'd30;
  localparam logic [7:0] PointBit            = 8'h08;
  localparam logic [3:0] EnableAllOff        = 4'hF;

  typedef struct packed {
    logic [1:0]  scan_position;
    logic [3:0]  digit_enable;
    logic [7:0]  segments;
    logic [15:0] count_bcd;
    logic [1:0]  cursor;
    logic        lamp_on;
  } result_t;

  // Seven-segment pattern of a decimal digit; out-of-range digits show as 9
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'b11010111;
      4'd1:    code = 8'b01010000;
      4'd2:    code = 8'b01100111;
      4'd3:    code = 8'b01110101;
      4'd4:    code = 8'b11110000;
      4'd5:    code = 8'b10110101;
      4'd6:    code = 8'b10110111;
      4'd7:    code = 8'b01010001;
      4'd8:    code = 8'b11110111;
      default: code = 8'b11110101;
    endcase
    return code;
  endfunction

  // Active-low digit enable of a scan position; positions four and up stay off
  function automatic logic [3:0] enable_code(input logic [2:0] pos);
    logic [3:0] code;
    case (pos)
      3'd0:    code = 4'hD;
      3'd1:    code = 4'hB;
      3'd2:    code = 4'h7;
      3'd3:    code = 4'hE;
      default: code = EnableAllOff;
    endcase
    return code;
  endfunction

endpackage

/* rtl/bcd_countdown_exposure_timer.sv */
// ----------------------------------------------------------------------------
// bcd_countdown_exposure_timer
// Decimal countdown exposure timer with encoder editing and segment scan.
// ----------------------------------------------------------------------------
//
//  channel   dir  fields (low bit first)
//  --------  ---  ----------------------------------------------------------
//  s_axis    in   tuser: cmd[2:0]; tdata: direction[0]
//  m_axis    out  tdata: lamp_on[0], cursor[2:1], count_bcd[18:3],
//                 segments[26:19], digit_enable[30:27], scan_position[32:31]
//  apb       in   reg 0 at 0x0: ticks_per_second[7:0]
//
//  The whole state update and its result come out of a single combinational
//  pass between the state registers and the result register, so a command is
//  accepted every cycle while the skid entry is empty.
//  Reset loads digits ...0,0,2,3, cursor on the rightmost digit, lamp off,
//  prescaler and reload at 30, scan at position 0.
//  A two-entry result buffer (output register plus skid) keeps s_axis_tready
//  high while one result waits; input stalls only once both entries are full.
//
module bcd_countdown_exposure_timer #(
  parameter int unsigned NUM_DIGITS = bcdcet_pkg::NumDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] direction
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // lamp_on, cursor, count_bcd, segments,
                                      // digit_enable, scan_position, zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // Timer state
  logic [3:0]      digits_q [NUM_DIGITS];
  logic [3:0]      digits_d [NUM_DIGITS];
  logic [IdxW-1:0] sel_q, sel_d;
  logic            running_q, running_d;
  logic [7:0]      prescale_q, prescale_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [7:0]      tps_q;

  // Result buffer
  bcdcet_pkg::result_t result_d, out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  logic in_xfer, out_xfer, cfg_write;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // Configuration port: writes land on the access cycle, reads are immediate
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == bcdcet_pkg::RegTicksPerSecond) ? {24'd0, tps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= bcdcet_pkg::TicksPerSecondReset;
    end else if (cfg_write && paddr[2] == bcdcet_pkg::RegTicksPerSecond) begin
      tps_q <= pwdata[7:0];
    end
  end

  bcdcet_step #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_step (
    .cmd_i              (s_axis_tuser),
    .direction_i        (s_axis_tdata[0]),
    .ticks_per_second_i (tps_q),
    .digits_i           (digits_q),
    .sel_i              (sel_q),
    .running_i          (running_q),
    .prescale_i         (prescale_q),
    .scan_i             (scan_q),
    .digits_o           (digits_d),
    .sel_o              (sel_d),
    .running_o          (running_d),
    .prescale_o         (prescale_d),
    .scan_o             (scan_d),
    .result_o           (result_d)
  );

  // Advance the timer state on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (k == int'(NUM_DIGITS) - 1) begin
          digits_q[k] <= 4'd3;
        end else if (k == int'(NUM_DIGITS) - 2) begin
          digits_q[k] <= 4'd2;
        end else begin
          digits_q[k] <= 4'd0;
        end
      end
      sel_q      <= IdxW'(NUM_DIGITS - 1);
      running_q  <= 1'b0;
      prescale_q <= bcdcet_pkg::TicksPerSecondReset;
      scan_q     <= '0;
    end else if (in_xfer) begin
      digits_q   <= digits_d;
      sel_q      <= sel_d;
      running_q  <= running_d;
      prescale_q <= prescale_d;
      scan_q     <= scan_d;
    end
  end

  // Output register with a skid entry behind it; the skid drains first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : result_d;
    end
    if (out_valid_q && !out_xfer && in_xfer) begin
      skid_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

endmodule

/* rtl/bcdcet_step.sv */
// ----------------------------------------------------------------------------
// bcdcet_step
// Next state and result of the timer for one command.
// ----------------------------------------------------------------------------
module bcdcet_step #(
  parameter int unsigned NUM_DIGITS = bcdcet_pkg::NumDigitsDefault,
  localparam int unsigned IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
  input  logic [2:0]      cmd_i,
  input  logic            direction_i,
  input  logic [7:0]      ticks_per_second_i,
  input  logic [3:0]      digits_i [NUM_DIGITS],
  input  logic [IdxW-1:0] sel_i,
  input  logic            running_i,
  input  logic [7:0]      prescale_i,
  input  logic [IdxW-1:0] scan_i,
  output logic [3:0]      digits_o [NUM_DIGITS],
  output logic [IdxW-1:0] sel_o,
  output logic            running_o,
  output logic [7:0]      prescale_o,
  output logic [IdxW-1:0] scan_o,
  output bcdcet_pkg::result_t result_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DIGITS - 1);

  logic [3:0]      cur_digit;
  logic [3:0]      scan_digit;
  logic [7:0]      prescale_dec;
  logic [NUM_DIGITS-1:0] right_zero;
  logic            all_zero;
  logic [3:0]      down_digits [NUM_DIGITS];
  logic [2:0]      scan_ext;

  assign cur_digit    = digits_i[sel_i];
  assign scan_digit   = digits_i[scan_i];
  assign prescale_dec = prescale_i - 8'd1;
  assign scan_ext     = 3'(scan_i);

  // Borrow chain: a digit takes the borrow when every digit to its right is 0
  always_comb begin
    logic rz;
    rz = 1'b1;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      right_zero[k] = rz;
      rz = rz & (digits_i[k] == 4'd0);
    end
    all_zero = rz;
  end

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (!right_zero[k]) begin
        down_digits[k] = digits_i[k];
      end else if (digits_i[k] == 4'd0) begin
        down_digits[k] = 4'd9;
      end else begin
        down_digits[k] = digits_i[k] - 4'd1;
      end
    end
  end

  always_comb begin
    digits_o   = digits_i;
    sel_o      = sel_i;
    running_o  = running_i;
    prescale_o = prescale_i;
    scan_o     = scan_i;
    result_o.segments      = 8'd0;
    result_o.digit_enable  = bcdcet_pkg::EnableAllOff;
    result_o.scan_position = 2'd0;

    case (cmd_i)
      bcdcet_pkg::CmdTick: begin
        if (running_i) begin
          if (prescale_dec == 8'd0) begin
            prescale_o = ticks_per_second_i;
            if (all_zero) begin
              running_o = 1'b0;
            end else begin
              digits_o = down_digits;
            end
          end else begin
            prescale_o = prescale_dec;
          end
        end
      end
      bcdcet_pkg::CmdEncode: begin
        if (!running_i) begin
          if (direction_i && cur_digit < 4'd9) begin
            digits_o[sel_i] = cur_digit + 4'd1;
          end else if (!direction_i && cur_digit > 4'd0) begin
            digits_o[sel_i] = cur_digit - 4'd1;
          end
        end
      end
      bcdcet_pkg::CmdCursor: begin
        if (!running_i) begin
          sel_o = (sel_i == '0) ? LastIdx : sel_i - IdxW'(1);
        end
      end
      bcdcet_pkg::CmdStart: begin
        if (!running_i) begin
          running_o  = 1'b1;
          prescale_o = ticks_per_second_i;
        end
      end
      bcdcet_pkg::CmdScan: begin
        result_o.segments = bcdcet_pkg::seg_code(scan_digit)
                          | ((scan_i == sel_i) ? bcdcet_pkg::PointBit : 8'd0);
        result_o.digit_enable  = bcdcet_pkg::enable_code(scan_ext);
        result_o.scan_position = scan_ext[1:0];
        scan_o = (scan_i == LastIdx) ? '0 : scan_i + IdxW'(1);
      end
      default: begin
      end
    endcase

    result_o.lamp_on = running_o;
    result_o.cursor  = 2'(3'(sel_o));

    // Pack the rightmost four digits after the update, leftmost in top nibble
    result_o.count_bcd = 16'd0;
    for (int j = 0; j < 4; j++) begin
      if (int'(NUM_DIGITS) - 1 - j >= 0) begin
        result_o.count_bcd[4*j +: 4] = digits_o[int'(NUM_DIGITS) - 1 - j];
      end
    end
  end

endmodule

/* bench/bcd_countdown_exposure_timer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_countdown_exposure_timer_test
// Stream-level test of the countdown timer. Commands go in on s_axis, and a
// local model of the digits, cursor, prescaler and scan predicts the readout
// of each transfer. Every readout taken from m_axis is checked field by field.
// Sessions go edit, start, tick down to stop, under several prescaler settings.
// ----------------------------------------------------------------------------

// Scoreboard: tracks the timer state and holds the readouts still due
class timer_scoreboard;
  logic [3:0]           digit [4];
  logic [1:0]           sel;
  bit                   running;
  logic [7:0]           prescale;
  logic [7:0]           reload;
  logic [1:0]           scan_pos;
  bcdcet_pkg::result_t  readouts_due [$];
  int                   mismatches;

  function new();
    digit    = '{4'd0, 4'd0, 4'd2, 4'd3};
    sel      = 2'd3;
    running  = 1'b0;
    prescale = 8'd30;
    reload   = 8'd30;
    scan_pos = 2'd0;
    mismatches = 0;
  endfunction

  function logic [15:0] count_bcd();
    return {digit[0], digit[1], digit[2], digit[3]};
  endfunction

  // Advance the state by one accepted command and queue its readout
  function void note_command(logic [2:0] cmd, logic dir);
    bcdcet_pkg::result_t r;
    bit borrowed;
    r = '0;
    r.digit_enable = bcdcet_pkg::EnableAllOff;
    case (cmd)
      bcdcet_pkg::CmdTick: begin
        if (running) begin
          prescale = prescale - 8'd1;
          if (prescale == 8'd0) begin
            prescale = reload;
            borrowed = 1'b0;
            // Decrement with decimal borrow; stop once the count was already zero
            for (int k = 3; k >= 0 && !borrowed; k--) begin
              if (digit[k] != 4'd0) begin
                digit[k] = digit[k] - 4'd1;
                for (int j = k + 1; j < 4; j++) digit[j] = 4'd9;
                borrowed = 1'b1;
              end
            end
            if (!borrowed) running = 1'b0;
          end
        end
      end
      bcdcet_pkg::CmdEncode: begin
        if (!running) begin
          if (dir && digit[sel] != 4'd9) digit[sel] = digit[sel] + 4'd1;
          else if (!dir && digit[sel] != 4'd0) digit[sel] = digit[sel] - 4'd1;
        end
      end
      bcdcet_pkg::CmdCursor: begin
        if (!running) sel = sel - 2'd1;
      end
      bcdcet_pkg::CmdStart: begin
        if (!running) begin
          running  = 1'b1;
          prescale = reload;
        end
      end
      bcdcet_pkg::CmdScan: begin
        case (digit[scan_pos])
          4'd0:    r.segments = 8'b11010111;
          4'd1:    r.segments = 8'b01010000;
          4'd2:    r.segments = 8'b01100111;
          4'd3:    r.segments = 8'b01110101;
          4'd4:    r.segments = 8'b11110000;
          4'd5:    r.segments = 8'b10110101;
          4'd6:    r.segments = 8'b10110111;
          4'd7:    r.segments = 8'b01010001;
          4'd8:    r.segments = 8'b11110111;
          default: r.segments = 8'b11110101;
        endcase
        if (scan_pos == sel) r.segments = r.segments | bcdcet_pkg::PointBit;
        case (scan_pos)
          2'd0:    r.digit_enable = 4'hD;
          2'd1:    r.digit_enable = 4'hB;
          2'd2:    r.digit_enable = 4'h7;
          default: r.digit_enable = 4'hE;
        endcase
        r.scan_position = scan_pos;
        scan_pos = scan_pos + 2'd1;
      end
      default: ;
    endcase
    r.lamp_on   = running;
    r.cursor    = sel;
    r.count_bcd = count_bcd();
    readouts_due.push_back(r);
  endfunction

  function void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: readout %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_readout(logic [39:0] data);
    bcdcet_pkg::result_t got, want;
    got = data[32:0];
    if (readouts_due.size() == 0) begin
      $display("%0t ns: readout with none due, expected nothing, got %h", $time, data);
      mismatches++;
      return;
    end
    want = readouts_due.pop_front();
    compare_field("lamp_on", 16'(want.lamp_on), 16'(got.lamp_on));
    compare_field("cursor", 16'(want.cursor), 16'(got.cursor));
    compare_field("count_bcd", want.count_bcd, got.count_bcd);
    compare_field("segments", 16'(want.segments), 16'(got.segments));
    compare_field("digit_enable", 16'(want.digit_enable), 16'(got.digit_enable));
    compare_field("scan_position", 16'(want.scan_position), 16'(got.scan_position));
    compare_field("pad", 16'h0, 16'(data[39:33]));
  endfunction
endclass

module bcd_countdown_exposure_timer_test;

  localparam int unsigned CycleLimit = 300000;
  // Byte addresses: the prescaler reload, and one slot that maps to nothing
  localparam logic [2:0] TicksAddr    = {bcdcet_pkg::RegTicksPerSecond, 2'b00};
  localparam logic [2:0] UnmappedAddr = 3'h4;
  // Highest code the command field can carry; codes above scan do nothing
  localparam logic [2:0] CmdLastCode  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [0] direction
  logic [2:0]  s_axis_tuser = 3'd0;    // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;           // lamp_on, cursor, count_bcd, segments,
                                       // digit_enable, scan_position, zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  timer_scoreboard sb = new();

  int items_sent = 0;
  int gap_pct = 10;     // chance of a sender gap before a transfer
  int stall_pct = 10;   // chance of a receiver stall burst
  int stall_left = 0;
  int cycle_count = 0;
  bit calm = 1'b0;      // set for the closing sessions: no idling on either side

  bcd_countdown_exposure_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: check each readout transfer, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_readout(m_axis_tdata);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[bcd_countdown_exposure_timer] ERROR");
    $finish;
  end

  // Offer one command and hold it until the block takes it. Valid stays high
  // afterwards so back-to-back transfers follow without a gap in valid.
  task automatic send_item(input logic [2:0] cmd, input logic dir);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, dir};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, dir);
    items_sent++;
  endtask

  // Drop valid and wait until every readout has come, plus a short guard
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.readouts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write a register; read the prescaler reload back
  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == TicksAddr) begin
      sb.reload = value;
      @(posedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== {24'd0, value}) begin
        $display("%0t ns: reload readback mismatch, expected %h, got %h",
                 $time, {24'd0, value}, prdata);
        sb.mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Move the cursor onto a digit and step it to the wanted value
  task automatic set_digit(input int pos, input logic [3:0] val);
    while (sb.sel != pos) send_item(bcdcet_pkg::CmdCursor, 1'($urandom_range(0, 1)));
    while (sb.digit[pos] != val) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(bcdcet_pkg::CmdScan, 1'($urandom_range(0, 1)));
      end
      send_item(bcdcet_pkg::CmdEncode, sb.digit[pos] < val);
    end
  endtask

  // Random editing while idle, with full-range bursts that hit saturation
  task automatic edit_noise(input int n);
    int   pick;
    logic dir;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      dir  = 1'($urandom_range(0, 1));
      if (pick < 40) send_item(bcdcet_pkg::CmdEncode, dir);
      else if (pick < 50) repeat (10) send_item(bcdcet_pkg::CmdEncode, dir);
      else if (pick < 65) send_item(bcdcet_pkg::CmdCursor, dir);
      else if (pick < 85) send_item(bcdcet_pkg::CmdScan, dir);
      else if (pick < 92) send_item(bcdcet_pkg::CmdTick, dir);
      else send_item(3'($urandom_range(bcdcet_pkg::CmdScan + 1, CmdLastCode)), dir);
    end
  endtask

  // Start the lamp and tick until it goes out; edits in between are ignored
  task automatic run_out();
    int   pick;
    logic dir;
    if (!sb.running) send_item(bcdcet_pkg::CmdStart, 1'($urandom_range(0, 1)));
    while (sb.running) begin
      pick = $urandom_range(0, 99);
      dir  = 1'($urandom_range(0, 1));
      if (pick < 80) send_item(bcdcet_pkg::CmdTick, dir);
      else if (pick < 88) send_item(bcdcet_pkg::CmdScan, dir);
      else if (pick < 92) send_item(bcdcet_pkg::CmdEncode, dir);
      else if (pick < 95) send_item(bcdcet_pkg::CmdCursor, dir);
      else if (pick < 97) send_item(bcdcet_pkg::CmdStart, dir);
      else send_item(3'($urandom_range(bcdcet_pkg::CmdScan + 1, CmdLastCode)), dir);
    end
    repeat ($urandom_range(1, 5)) send_item(bcdcet_pkg::CmdScan, 1'($urandom_range(0, 1)));
  endtask

  // One exposure: set the reload, edit, dial in a count in [lo, hi], run out
  task automatic run_session(input logic [7:0] tps, input int lo, input int hi);
    int n;
    settle();
    gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
    write_reg(TicksAddr, tps);
    edit_noise($urandom_range(4, 16));
    n = $urandom_range(lo, hi);
    for (int k = 3; k >= 0; k--) begin
      set_digit(k, 4'(n % 10));
      n = n / 10;
    end
    run_out();
  endtask

  initial begin
    int   pick;
    bit   hundreds_done;
    hundreds_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset readout, idle tick, unused codes, saturation at zero,
    // cursor wrap, then edits and restart while the lamp is on
    repeat (4) send_item(bcdcet_pkg::CmdScan, 1'b0);
    send_item(bcdcet_pkg::CmdTick, 1'b1);
    for (int c = bcdcet_pkg::CmdScan + 1; c <= CmdLastCode; c++) send_item(3'(c), c[0]);
    repeat (4) send_item(bcdcet_pkg::CmdEncode, 1'b0);
    send_item(bcdcet_pkg::CmdCursor, 1'b1);
    repeat (3) send_item(bcdcet_pkg::CmdEncode, 1'b0);
    repeat (2) send_item(bcdcet_pkg::CmdCursor, 1'b0);
    send_item(bcdcet_pkg::CmdEncode, 1'b1);
    send_item(bcdcet_pkg::CmdEncode, 1'b0);
    send_item(bcdcet_pkg::CmdCursor, 1'b1);
    send_item(bcdcet_pkg::CmdEncode, 1'b1);
    send_item(bcdcet_pkg::CmdStart, 1'b0);
    send_item(bcdcet_pkg::CmdEncode, 1'b1);
    send_item(bcdcet_pkg::CmdCursor, 1'b0);
    send_item(bcdcet_pkg::CmdStart, 1'b1);
    send_item(bcdcet_pkg::CmdScan, 1'b0);
    run_out();

    // Largest reload and the 8-bit wrap of zero, both started from all zeros
    run_session(8'd255, 0, 0);
    run_session(8'd0, 0, 0);

    // An unmapped write must leave the reload alone
    settle();
    write_reg(UnmappedAddr, 8'($urandom()));

    while (items_sent < 820) begin
      if (items_sent >= 760) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (!hundreds_done) begin
        // borrow through the tens into the hundreds digit
        run_session(8'd1, 100, 115);
        hundreds_done = 1'b1;
      end else if (pick < 65) begin
        pick = $urandom_range(1, 4);
        run_session(8'(pick), 0, (pick == 1) ? 60 : 25);
      end else begin
        run_session(8'($urandom_range(5, 12)), 0, 3);
      end
    end

    // Closing session without idling on either side
    calm = 1'b1;
    run_session(8'd2, 0, 5);

    settle();
    if (sb.mismatches == 0) begin
      $display("[bcd_countdown_exposure_timer] OK");
    end else begin
      $display("[bcd_countdown_exposure_timer] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bcdcet_pkg.sv
rtl/bcdcet_step.sv
rtl/bcd_countdown_exposure_timer.sv
bench/bcd_countdown_exposure_timer_test.sv
